FILE: hw/rtl/mdq_pkg.sv
// Shared types, constants and the period table of the quadrature emulator.
package mdq_pkg;

  // Width of each axis pending-step count
  localparam int PENDING_BITS = 8;
  localparam int PEND_CAP     = (1 << PENDING_BITS) - 1;

  // Count clip applied before the period table, and the period of an idle axis
  localparam int COUNT_CLIP   = 127;
  localparam int PERIOD_IDLE  = 255;

  // Bit-serial divider: magnitude and divisor widths, one quotient bit per cycle
  localparam int MAG_W        = 8;
  localparam int DVS_W        = 7;
  localparam int DIV_STEPS    = MAG_W;

  // Configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DPI_DIVIDE_ENABLE = 3'd0,
    CFG_DELTA_DIVISOR     = 3'd1,
    CFG_RATE_LIMIT_ENABLE = 3'd2,
    CFG_RATE_LIMIT_PERIOD = 3'd3,
    CFG_PENDING_LIMIT     = 3'd4
  } mdq_cfg_idx_t;

  // Request kinds
  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef struct packed {
    logic             dpi_divide_enable;
    logic [DVS_W-1:0] delta_divisor;
    logic             rate_limit_enable;
    logic [7:0]       rate_limit_period;
    logic [7:0]       pending_limit;
  } mdq_cfg_t;

  typedef struct packed {
    logic              req_type;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
  } mdq_in_t;

  typedef struct packed {
    logic       x_line_a;
    logic       x_line_b;
    logic       y_line_a;
    logic       y_line_b;
    logic [7:0] x_period_now;
    logic [7:0] y_period_now;
    logic [7:0] x_remaining;
    logic [7:0] y_remaining;
  } mdq_out_t;

  // Sequencer strobes to each axis
  typedef struct packed {
    logic div_start;
    logic report_apply;
    logic tick_apply;
  } mdq_axis_ctrl_t;

  // Step period for a clipped count c: (10000 / c) / 64 - 1
  function automatic logic [7:0] period_lut(input logic [6:0] c);
    logic [7:0] p;
    priority if (c >= 7'd79) p = 8'd0;
    else if (c >= 7'd53) p = 8'd1;
    else if (c >= 7'd40) p = 8'd2;
    else if (c >= 7'd32) p = 8'd3;
    else if (c >= 7'd27) p = 8'd4;
    else if (c >= 7'd23) p = 8'd5;
    else if (c >= 7'd20) p = 8'd6;
    else if (c >= 7'd18) p = 8'd7;
    else if (c >= 7'd16) p = 8'd8;
    else begin
      unique case (c)
        7'd1:    p = 8'd155;
        7'd2:    p = 8'd77;
        7'd3:    p = 8'd51;
        7'd4:    p = 8'd38;
        7'd5:    p = 8'd30;
        7'd6:    p = 8'd25;
        7'd7:    p = 8'd21;
        7'd8:    p = 8'd18;
        7'd9:    p = 8'd16;
        7'd10:   p = 8'd14;
        7'd11:   p = 8'd13;
        7'd12:   p = 8'd12;
        7'd13:   p = 8'd11;
        7'd14:   p = 8'd10;
        7'd15:   p = 8'd9;
        default: p = 8'(PERIOD_IDLE);
      endcase
    end
    return p;
  endfunction

endpackage

FILE: hw/rtl/mdq_serial_div.sv
// Restoring divider, one quotient bit per cycle, MSB first
module mdq_serial_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mdq_pkg::MAG_W-1:0] dividend,
  input  logic [mdq_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [mdq_pkg::MAG_W-1:0] quotient
);

  localparam int MW    = mdq_pkg::MAG_W;
  localparam int DW    = mdq_pkg::DVS_W;
  localparam int CNT_W = $clog2(mdq_pkg::DIV_STEPS);

  logic              running_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MW-1:0]     quo_r;
  logic [MW-1:0]     quo_nxt;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     rem_nxt;
  logic [DW-1:0]     dvs_r;
  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic              fits;
  logic              last;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial   = {rem_r, quo_r[MW-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign fits    = trial >= {1'b0, dvs_r};
  assign rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
  assign quo_nxt = {quo_r[MW-2:0], fits};
  assign last    = cnt_r == CNT_W'(mdq_pkg::DIV_STEPS - 1);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= running_r && last;
      if (start) begin
        running_r <= 1'b1;
        cnt_r     <= '0;
      end else if (running_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last) running_r <= 1'b0;
      end
    end
  end

  // Datapath: quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (running_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/mdq_axis.sv
// One axis: direction, pending count, period, tick counter, phase and its line pair.
// Lead is the line moved on even phases, lag the one moved on odd phases.
module mdq_axis (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mdq_pkg::mdq_axis_ctrl_t          ctrl,
  input  mdq_pkg::mdq_cfg_t                cfg,
  input  logic signed [7:0]                delta,
  output logic                             div_done,
  output logic                             lead,
  output logic                             lag,
  output logic [7:0]                       period,
  output logic [mdq_pkg::PENDING_BITS-1:0] pending
);

  localparam int PB    = mdq_pkg::PENDING_BITS;
  localparam int SUM_W = PB + 1;
  localparam int MW    = mdq_pkg::MAG_W;
  localparam int DW    = mdq_pkg::DVS_W;

  logic          dir_r, dir_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [PB-1:0] pending_r, pending_nxt;
  logic [7:0]    period_r, period_nxt;
  logic [7:0]    tick_r, tick_nxt;
  logic          lead_r, lead_nxt;
  logic          lag_r, lag_nxt;

  logic [MW-1:0]    mag;
  logic             mag_nz;
  logic [DW-1:0]    dvs;
  logic [MW-1:0]    quo;
  logic [MW-1:0]    step;
  logic [PB-1:0]    base;
  logic             rpt_dir;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] lim;
  logic [SUM_W-1:0] sat;
  logic [PB-1:0]    rpt_pending;
  logic [6:0]       clip;
  logic [7:0]       rpt_period;
  logic [7:0]       expire_len;
  logic             expired;

  // Magnitude of the delta; -128 gives 128
  assign mag    = delta[7] ? (MW'(0) - MW'(delta)) : MW'(delta);
  assign mag_nz = |mag;
  // Divide by one when division is off or the divider is zero
  assign dvs    = (cfg.dpi_divide_enable && (cfg.delta_divisor != '0)) ?
                  cfg.delta_divisor : DW'(1);

  mdq_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (mag),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // Report: reversal or zero delta clears count, add scaled step, saturate, period
  always_comb begin
    base    = pending_r;
    rpt_dir = dir_r;
    if (mag_nz && !delta[7] && !dir_r) begin
      base    = '0;
      rpt_dir = 1'b1;
    end else if (mag_nz && delta[7] && dir_r) begin
      base    = '0;
      rpt_dir = 1'b0;
    end
    step        = (quo == '0) ? MW'(1) : quo;
    sum         = mag_nz ? (SUM_W'(base) + SUM_W'(step)) : '0;
    lim         = (sum > SUM_W'(cfg.pending_limit)) ? SUM_W'(cfg.pending_limit) : sum;
    sat         = (lim > SUM_W'(mdq_pkg::PEND_CAP)) ? SUM_W'(mdq_pkg::PEND_CAP) : lim;
    rpt_pending = PB'(sat);
    clip        = (rpt_pending > PB'(mdq_pkg::COUNT_CLIP)) ?
                  7'(mdq_pkg::COUNT_CLIP) : rpt_pending[6:0];
    rpt_period  = (clip == '0) ? 8'(mdq_pkg::PERIOD_IDLE) : mdq_pkg::period_lut(clip);
    if (cfg.rate_limit_enable && (rpt_period < cfg.rate_limit_period)) begin
      rpt_period = cfg.rate_limit_period;
    end
  end

  // Tick expiry; a zero period counts as one
  assign expire_len = (period_r == '0) ? 8'd1 : period_r;
  assign expired    = tick_r >= expire_len;

  // Next state
  always_comb begin
    dir_nxt     = dir_r;
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    period_nxt  = period_r;
    tick_nxt    = tick_r;
    lead_nxt    = lead_r;
    lag_nxt     = lag_r;
    if (ctrl.report_apply) begin
      dir_nxt     = rpt_dir;
      pending_nxt = rpt_pending;
      period_nxt  = rpt_period;
    end else if (ctrl.tick_apply) begin
      if (!expired) begin
        tick_nxt = tick_r + 8'd1;
      end else begin
        tick_nxt = '0;
        if (pending_r == '0) begin
          phase_nxt = '0;
        end else begin
          // upper phase bit gives the level driven
          if (phase_r[0]) lag_nxt  = phase_r[1];
          else            lead_nxt = phase_r[1];
          phase_nxt   = dir_r ? (phase_r + 2'd1) : (phase_r - 2'd1);
          pending_nxt = pending_r - PB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r     <= 1'b0;
      phase_r   <= '0;
      pending_r <= '0;
      period_r  <= 8'd1;
      tick_r    <= '0;
      lead_r    <= 1'b1;
      lag_r     <= 1'b1;
    end else begin
      dir_r     <= dir_nxt;
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
      period_r  <= period_nxt;
      tick_r    <= tick_nxt;
      lead_r    <= lead_nxt;
      lag_r     <= lag_nxt;
    end
  end

  assign lead    = lead_r;
  assign lag     = lag_r;
  assign period  = period_r;
  assign pending = pending_r;

`ifndef ASSERT_OFF
  // Lines move only on a tick
  a_lines_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.tick_apply |=> ($stable(lead_r) && $stable(lag_r)))
    else $error("quadrature line changed without a tick");

  // A tick never raises the pending count
  a_tick_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.tick_apply |=> (pending_r <= $past(pending_r)))
    else $error("pending count grew on a tick");

  // The period is recomputed on reports only
  a_period_report_only: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.report_apply |=> $stable(period_r))
    else $error("period changed outside a report");
`endif

endmodule

FILE: hw/rtl/mouse_delta_to_quadrature_core.sv
// Turns relative mouse movement reports and 64 us timer ticks into quadrature
// edges on an X and a Y line pair, one result per request with the line levels,
// the step period and the pending step count of each axis. A tick request passes
// the apply and load states; a movement report first passes the start and divide
// states, where the bit-serial divider scales the delta magnitudes (one quotient
// bit per cycle, both axes in parallel). One request is in flight at a time; a
// new one is taken once the previous result sits in the output register, and a
// stalled result holds the next one back from completing. Configuration writes
// are always ready and must only be issued while no request is in flight.
module mouse_delta_to_quadrature_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mdq_pkg::mdq_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mdq_pkg::mdq_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mdq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mdq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PB = mdq_pkg::PENDING_BITS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_APPLY = 5'b01000,
    ST_LOAD  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  mdq_pkg::mdq_cfg_t       cfg_r;
  mdq_pkg::mdq_in_t        req_r;
  mdq_pkg::mdq_out_t       out_data_r, out_data_nxt;
  logic                    out_valid_r, out_valid_nxt;
  mdq_pkg::mdq_axis_ctrl_t ctrl;
  logic                    in_take;
  logic                    out_load;
  logic                    x_done, y_done;
  logic                    x_lead, x_lag, y_lead, y_lag;
  logic [7:0]              x_period, y_period;
  logic [PB-1:0]           x_pending, y_pending;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dpi_divide_enable <= 1'b0;
      cfg_r.delta_divisor     <= 7'd2;
      cfg_r.rate_limit_enable <= 1'b0;
      cfg_r.rate_limit_period <= 8'd1;
      cfg_r.pending_limit     <= 8'd127;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mdq_pkg::CFG_DPI_DIVIDE_ENABLE: cfg_r.dpi_divide_enable <= cfg_data[0];
        mdq_pkg::CFG_DELTA_DIVISOR:     cfg_r.delta_divisor     <= cfg_data[6:0];
        mdq_pkg::CFG_RATE_LIMIT_ENABLE: cfg_r.rate_limit_enable <= cfg_data[0];
        mdq_pkg::CFG_RATE_LIMIT_PERIOD: cfg_r.rate_limit_period <= cfg_data;
        mdq_pkg::CFG_PENDING_LIMIT:     cfg_r.pending_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request capture
  assign in_stall = state_r != ST_IDLE;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_take) req_r <= in_data;
  end

  // Sequencer
  assign out_load = (state_r == ST_LOAD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_take) state_nxt = (in_data.req_type == mdq_pkg::REQ_TICK) ?
                                         ST_APPLY : ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (x_done && y_done) state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_LOAD;
      ST_LOAD:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign ctrl.div_start    = state_r == ST_START;
  assign ctrl.report_apply = (state_r == ST_APPLY) && (req_r.req_type == mdq_pkg::REQ_REPORT);
  assign ctrl.tick_apply   = (state_r == ST_APPLY) && (req_r.req_type == mdq_pkg::REQ_TICK);

  // Axes; Y moves its second line on even phases
  mdq_axis u_axis_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .cfg      (cfg_r),
    .delta    (req_r.delta_x),
    .div_done (x_done),
    .lead     (x_lead),
    .lag      (x_lag),
    .period   (x_period),
    .pending  (x_pending)
  );

  mdq_axis u_axis_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .cfg      (cfg_r),
    .delta    (req_r.delta_y),
    .div_done (y_done),
    .lead     (y_lead),
    .lag      (y_lag),
    .period   (y_period),
    .pending  (y_pending)
  );

  // Output register
  always_comb begin
    out_data_nxt.x_line_a     = x_lead;
    out_data_nxt.x_line_b     = x_lag;
    out_data_nxt.y_line_a     = y_lag;
    out_data_nxt.y_line_b     = y_lead;
    out_data_nxt.x_period_now = x_period;
    out_data_nxt.y_period_now = y_period;
    out_data_nxt.x_remaining  = 8'(x_pending);
    out_data_nxt.y_remaining  = 8'(y_pending);
    out_valid_nxt = out_valid_r;
    if (out_load)                       out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // Both axis dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    x_done == y_done)
    else $error("axis dividers out of step");

  // Each divider start is followed by done while the sequencer waits in the divide state
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START) |-> ##9 (x_done && (state_r == ST_DIV)))
    else $error("divider did not finish on time");

  // A tick with an empty output register reaches its result via apply and load
  a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (in_data.req_type == mdq_pkg::REQ_TICK) && !out_valid_r)
    |-> ##3 out_valid_r)
    else $error("tick result late");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT      = 2_000_000;
  localparam int SETTLE_CYCLES    = 16;
  localparam int RAND_PER_SETTING = 275;
  localparam int PLAN_LEN         = 25;
  // period = (RATE_NUM / count) / TICK_DIV - 1
  localparam int RATE_NUM         = 10000;
  localparam int TICK_DIV         = 64;

  typedef struct packed {
    logic                             dir;
    logic [1:0]                       phase;
    logic [mdq_pkg::PENDING_BITS-1:0] pending;
    logic [7:0]                       period;
    logic [7:0]                       tick_count;
  } axis_t;

  // one directed row: typed_in set means want is typed in, else predicted
  typedef struct packed {
    logic              typed_in;
    mdq_pkg::mdq_in_t  req;
    mdq_pkg::mdq_out_t want;
  } plan_row_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  mdq_pkg::mdq_in_t               in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  mdq_pkg::mdq_out_t              out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mdq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mdq_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor state and its copy of the registers
  axis_t      axes [2];
  logic [3:0] line_lvl;
  logic       m_div_en;
  logic [6:0] m_divisor;
  logic       m_rl_en;
  logic [7:0] m_rl_period;
  logic [7:0] m_pend_limit;

  mdq_pkg::mdq_out_t awaited_status [$];
  plan_row_t         plan [PLAN_LEN];
  logic [1:0]        lean = 2'b00;
  bit                idling = 1'b1;
  int                stall_left = 0;
  int                mismatches = 0;
  int                results_seen = 0;
  int                sent = 0;
  int                settings = 0;
  int                edges = 0;
  int                cycles = 0;
  mdq_pkg::mdq_out_t got_status;

  always #2 clk = ~clk;

  mouse_delta_to_quadrature_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic void reset_model();
    m_div_en     = 1'b0;
    m_divisor    = 7'd2;
    m_rl_en      = 1'b0;
    m_rl_period  = 8'd1;
    m_pend_limit = 8'd127;
    for (int i = 0; i < 2; i++) begin
      axes[i]        = '0;
      axes[i].period = 8'd1;
    end
    line_lvl = 4'hF;
  endfunction

  // movement report on one axis: reversal, accumulate, saturate, new period
  function automatic void apply_report(input int i, input logic signed [7:0] delta);
    int mag;
    int dv;
    int pend;
    int clip;
    int per;
    mag = (delta < 0) ? -int'(delta) : int'(delta);
    if (mag != 0 && delta > 0 && !axes[i].dir) begin
      axes[i].pending = '0;
      axes[i].dir     = 1'b1;
    end else if (mag != 0 && delta < 0 && axes[i].dir) begin
      axes[i].pending = '0;
      axes[i].dir     = 1'b0;
    end
    if (mag == 0) begin
      pend = 0;
    end else begin
      if (m_div_en) begin
        // a divider of zero behaves as one
        dv  = (m_divisor == 7'd0) ? 1 : int'(m_divisor);
        mag = mag / dv;
        if (mag < 1) mag = 1;
      end
      pend = int'(axes[i].pending) + mag;
    end
    if (pend > int'(m_pend_limit)) pend = int'(m_pend_limit);
    if (pend > mdq_pkg::PEND_CAP) pend = mdq_pkg::PEND_CAP;
    clip = (pend > mdq_pkg::COUNT_CLIP) ? mdq_pkg::COUNT_CLIP : pend;
    per  = (clip == 0) ? mdq_pkg::PERIOD_IDLE : (RATE_NUM / clip) / TICK_DIV - 1;
    if (m_rl_en && per < int'(m_rl_period)) per = int'(m_rl_period);
    axes[i].pending = pend[mdq_pkg::PENDING_BITS-1:0];
    axes[i].period  = per[7:0];
  endfunction

  // timer tick on one axis; Y drives its pair in the opposite line order
  function automatic void step_tick(input int i);
    logic [7:0] lim;
    int         b;
    lim = (axes[i].period == 8'd0) ? 8'd1 : axes[i].period;
    if (axes[i].tick_count < lim) begin
      axes[i].tick_count = axes[i].tick_count + 8'd1;
    end else begin
      axes[i].tick_count = '0;
      if (axes[i].pending == '0) begin
        axes[i].phase = 2'd0;
      end else begin
        b = 2 * i + int'(axes[i].phase[0] ^ (i == 1));
        line_lvl[b] = axes[i].phase[1];
        axes[i].phase = axes[i].dir ? axes[i].phase + 2'd1 : axes[i].phase - 2'd1;
        axes[i].pending = axes[i].pending - 1'b1;
        edges++;
      end
    end
  endfunction

  function automatic mdq_pkg::mdq_out_t expected_status(input mdq_pkg::mdq_in_t req);
    mdq_pkg::mdq_out_t s;
    if (req.req_type == mdq_pkg::REQ_TICK) begin
      step_tick(0);
      step_tick(1);
    end else begin
      apply_report(0, req.delta_x);
      apply_report(1, req.delta_y);
    end
    s.x_line_a     = line_lvl[0];
    s.x_line_b     = line_lvl[1];
    s.y_line_a     = line_lvl[2];
    s.y_line_b     = line_lvl[3];
    s.x_period_now = axes[0].period;
    s.y_period_now = axes[1].period;
    s.x_remaining  = 8'(axes[0].pending);
    s.y_remaining  = 8'(axes[1].pending);
    return s;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // mostly short idle spells, now and then a long one
  function automatic int idle_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 85) return int'($urandom_range(1, 3));
    else if (r < 97) return int'($urandom_range(4, 20));
    return int'($urandom_range(30, 120));
  endfunction

  // deltas keep a leaning direction per axis so counts build up
  function automatic logic signed [7:0] random_delta(input int i);
    int                 pick;
    logic [7:0]         mag;
    logic signed [7:0]  d;
    if ($urandom_range(0, 15) == 0) lean[i] = ~lean[i];
    pick = int'($urandom_range(0, 9));
    if (pick < 2) begin
      d = '0;
    end else if (pick < 6) begin
      mag = 8'($urandom_range(1, 127));
      d   = lean[i] ? -mag : mag;
    end else if (pick < 9) begin
      mag = 8'($urandom_range(1, 8));
      d   = $urandom_range(0, 1) ? -mag : mag;
    end else begin
      d = 8'($urandom_range(0, 255));
    end
    return d;
  endfunction

  function automatic mdq_pkg::mdq_in_t random_request();
    mdq_pkg::mdq_in_t r;
    r.req_type = ($urandom_range(0, 99) < 72) ? mdq_pkg::REQ_TICK : mdq_pkg::REQ_REPORT;
    r.delta_x  = random_delta(0);
    r.delta_y  = random_delta(1);
    return r;
  endfunction

  // offer one request, wait for it to be taken, then queue its status
  task automatic push_request(input mdq_pkg::mdq_in_t req, input logic typed_in,
                              input mdq_pkg::mdq_out_t want);
    mdq_pkg::mdq_out_t s;
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    s = expected_status(req);
    awaited_status.push_back(typed_in ? want : s);
    sent++;
  endtask

  task automatic sender_pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every status has come back and the block has settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input mdq_pkg::mdq_cfg_idx_t idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mdq_pkg::CFG_DPI_DIVIDE_ENABLE: m_div_en     = val[0];
      mdq_pkg::CFG_DELTA_DIVISOR:     m_divisor    = val[6:0];
      mdq_pkg::CFG_RATE_LIMIT_ENABLE: m_rl_en      = val[0];
      mdq_pkg::CFG_RATE_LIMIT_PERIOD: m_rl_period  = val;
      mdq_pkg::CFG_PENDING_LIMIT:     m_pend_limit = val;
      default: ;
    endcase
  endtask

  // program all registers, then a block of random requests
  task automatic run_setting(input logic div_en, input logic [7:0] divisor, input logic rl_en,
                             input logic [7:0] rl_period, input logic [7:0] pend_limit);
    cfg_beat(mdq_pkg::CFG_DPI_DIVIDE_ENABLE, {7'd0, div_en});
    cfg_beat(mdq_pkg::CFG_DELTA_DIVISOR, divisor);
    cfg_beat(mdq_pkg::CFG_RATE_LIMIT_ENABLE, {7'd0, rl_en});
    cfg_beat(mdq_pkg::CFG_RATE_LIMIT_PERIOD, rl_period);
    cfg_beat(mdq_pkg::CFG_PENDING_LIMIT, pend_limit);
    cfg_valid <= 1'b0;
    settings++;
    for (int k = 0; k < RAND_PER_SETTING; k++) begin
      if (k % 40 == 0) idling = ($urandom_range(0, 3) != 0);
      push_request(random_request(), 1'b0, '0);
      sender_pause((idling && $urandom_range(0, 1) == 1) ? idle_len() : 0);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------- receiver

  // random output back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idling && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left = idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // compare each delivered status with the oldest awaited one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_status.size() == 0) begin
        $error("status delivered with none awaited");
        mismatches++;
      end else begin
        got_status = awaited_status.pop_front();
        check_field("x_line_a", got_status.x_line_a, out_data.x_line_a);
        check_field("x_line_b", got_status.x_line_b, out_data.x_line_b);
        check_field("y_line_a", got_status.y_line_a, out_data.y_line_a);
        check_field("y_line_b", got_status.y_line_b, out_data.y_line_b);
        check_field("x_period_now", got_status.x_period_now, out_data.x_period_now);
        check_field("y_period_now", got_status.y_period_now, out_data.y_period_now);
        check_field("x_remaining", got_status.x_remaining, out_data.x_remaining);
        check_field("y_remaining", got_status.y_remaining, out_data.y_remaining);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // deltas as raw bytes: 7F = +127, 81 = -127, 80 = -128, FF = -1, 40 = +64
    plan = '{
      // straight after reset: periods 1, nothing pending, lines released
      {1'b1, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 4'hF, 8'd1,   8'd1,   8'd0,   8'd0},
      {1'b1, mdq_pkg::REQ_TICK,   8'hFF, 8'hFF, 4'hF, 8'd1,   8'd1,   8'd0,   8'd0},
      // zero report idles both axes
      {1'b1, mdq_pkg::REQ_REPORT, 8'h00, 8'h00, 4'hF, 8'd255, 8'd255, 8'd0,   8'd0},
      // full scale both ways: count at the limit, fastest period
      {1'b1, mdq_pkg::REQ_REPORT, 8'h7F, 8'h81, 4'hF, 8'd0,   8'd0,   8'd127, 8'd127},
      // -128 reverses X and saturates, Y reverses to a single step
      {1'b0, mdq_pkg::REQ_REPORT, 8'h80, 8'h01, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'hAA, 8'h55, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h55, 8'hAA, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      // both axes turn round again
      {1'b0, mdq_pkg::REQ_REPORT, 8'h01, 8'hFF, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_REPORT, 8'hFF, 8'h7F, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_REPORT, 8'h00, 8'h80, 36'd0},
      {1'b0, mdq_pkg::REQ_TICK,   8'h00, 8'h00, 36'd0},
      {1'b0, mdq_pkg::REQ_REPORT, 8'h40, 8'h00, 36'd0}
    };
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under the reset settings
    for (int k = 0; k < PLAN_LEN; k++) begin
      push_request(plan[k].req, plan[k].typed_in, plan[k].want);
      sender_pause(($urandom_range(0, 2) == 0) ? idle_len() : 0);
    end
    wait_drained();

    // random blocks: reset values, then the extremes of each register, then a random and a mixed setting
    run_setting(1'b0, 8'd2,   1'b0, 8'd1,   8'd127);
    run_setting(1'b1, 8'd1,   1'b1, 8'd0,   8'd255);
    run_setting(1'b1, 8'd127, 1'b0, 8'd255, 8'd1);
    run_setting(1'b1, 8'd0,   1'b1, 8'd255, 8'd0);
    run_setting(1'b1, 8'($urandom_range(2, 12)), 1'b1, 8'($urandom_range(0, 30)),
                8'($urandom_range(1, 255)));
    run_setting(1'b0, 8'd127, 1'b1, 8'd3,   8'd200);

    $display("Checked %0d statuses for %0d requests (%0d directed) over %0d register settings,",
             results_seen, sent, PLAN_LEN, settings);
    $display("with %0d quadrature edges driven along the way.", edges);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mdq_pkg.sv
hw/rtl/mdq_serial_div.sv
hw/rtl/mdq_axis.sv
hw/rtl/mouse_delta_to_quadrature_core.sv
dv/tb.sv
